/* hdl/assert_macros.svh */
// Assertion macros used by the mixer's top-level RTL file.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define JMWM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("jmwm: assertion failed");

// An antecedent that, when true, requires the consequent in the same cycle.
`define JMWM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jmwm: assertion failed");

`endif

/* hdl/jmwm_pkg.sv */
// Package for the joystick mecanum wheel mixer: register map, payload types and
// the arithmetic helpers used by the pipeline stages. No dependencies.
package jmwm_pkg;

  localparam int DutyW = 14;
  localparam int DeadW = 7;
  localparam int AxisW = 8;
  localparam int DirW  = 2;
  localparam int ValW  = DutyW + 1;  // signed wheel value before mixing
  localparam int SumW  = DutyW + 2;  // signed mixed value
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [AxisW-1:0] Centre = 8'd127;

  localparam int SpinRightBit = 1;
  localparam int SpinLeftBit  = 2;

  localparam logic [DirW-1:0] DIR_STOP = 2'd0;
  localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
  localparam logic [DirW-1:0] DIR_BACK = 2'd2;

  localparam logic [1:0] REG_MAX_DUTY   = 2'd0;
  localparam logic [1:0] REG_MIN_DUTY   = 2'd1;
  localparam logic [1:0] REG_DEADBAND   = 2'd2;
  localparam logic [1:0] REG_SPIN_SPEED = 2'd3;

  localparam logic [DutyW-1:0] MaxDutyReset   = 14'd1000;
  localparam logic [DutyW-1:0] MinDutyReset   = 14'd0;
  localparam logic [DeadW-1:0] DeadbandReset  = 7'd10;
  localparam logic [DutyW-1:0] SpinSpeedReset = 14'd550;

  typedef struct packed {
    logic [DutyW-1:0] max_duty;
    logic [DutyW-1:0] min_duty;
    logic [DeadW-1:0] deadband;
    logic [DutyW-1:0] spin_speed;
  } cfg_t;

  // Scaled axes handed from the scale stage to the mix stage. With spin set,
  // str holds the signed left wheel speed and fwd is zero.
  typedef struct packed {
    logic                   valid;
    logic                   spin;
    logic signed [ValW-1:0] fwd;
    logic signed [ValW-1:0] str;
  } mid_t;

  typedef struct packed {
    logic             seen;
  } status_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [DirW-1:0]  dir;
  } wheel_t;

  // Dead zone, then (v-127)*max/128 truncated toward zero.
  function automatic logic signed [ValW-1:0] axis_map(input logic [AxisW-1:0] v,
                                                      input logic [DeadW-1:0] dz,
                                                      input logic [DutyW-1:0] mx);
    logic [AxisW:0]   hi_edge;
    logic [AxisW-1:0] lo_edge;
    logic [AxisW-1:0] offset;
    logic [21:0]      prod;
    logic [DutyW-1:0] mag;
    logic             neg;
    hi_edge = {1'b0, Centre} + {2'b00, dz};
    lo_edge = Centre - {1'b0, dz};
    neg     = (v < lo_edge);
    offset  = '0;
    if ({1'b0, v} > hi_edge) begin
      offset = v - Centre;
    end else if (neg) begin
      offset = Centre - v;
    end
    prod = {14'd0, offset} * {8'd0, mx};
    // The distance never exceeds 128, so the quotient never exceeds max.
    mag = prod[20:7];
    if (neg) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

  function automatic logic signed [SumW-1:0] clamp_mag(input logic signed [SumW-1:0] v,
                                                       input logic [DutyW-1:0] mx);
    logic signed [SumW-1:0] lim;
    lim = $signed({2'b00, mx});
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic wheel_t wheel_drive(input logic signed [SumW-1:0] v,
                                         input logic [DutyW-1:0] mn);
    logic [SumW-1:0] mag;
    wheel_t          w;
    mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
    w.duty = '0;
    w.dir  = DIR_STOP;
    if (mag > {2'b00, mn}) begin
      w.duty = mag[DutyW-1:0];
      w.dir  = v[SumW-1] ? DIR_BACK : DIR_FWD;
    end
    return w;
  endfunction

endpackage

/* hdl/jmwm_stick_if.sv */
// Stick sample channel and wheel result channel of the mixer.
// Depends on jmwm_pkg for field widths.
interface jmwm_stick_if;
  import jmwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [AxisW-1:0] stick_x;
  logic [AxisW-1:0] stick_y;
  logic [AxisW-1:0] buttons;

  modport source (output valid, output stick_x, output stick_y, output buttons,
                  input ready);
  modport sink   (input valid, input stick_x, input stick_y, input buttons,
                  output ready);
endinterface

interface jmwm_wheel_if;
  import jmwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] front_left_duty;
  logic [DirW-1:0]  front_left_dir;
  logic [DutyW-1:0] front_right_duty;
  logic [DirW-1:0]  front_right_dir;
  logic [DutyW-1:0] rear_left_duty;
  logic [DirW-1:0]  rear_left_dir;
  logic [DutyW-1:0] rear_right_duty;
  logic [DirW-1:0]  rear_right_dir;

  modport source (output valid, output front_left_duty, output front_left_dir,
                  output front_right_duty, output front_right_dir,
                  output rear_left_duty, output rear_left_dir,
                  output rear_right_duty, output rear_right_dir, input ready);
  modport sink   (input valid, input front_left_duty, input front_left_dir,
                  input front_right_duty, input front_right_dir,
                  input rear_left_duty, input rear_left_dir,
                  input rear_right_duty, input rear_right_dir, output ready);
endinterface

/* hdl/jmwm_cfg_regs.sv */
// APB-style configuration registers of the mixer.
// Depends on jmwm_pkg for the register map and cfg_t.
module jmwm_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jmwm_pkg::AddrW-1:0] paddr,
  input  logic [jmwm_pkg::DataW-1:0] pwdata,
  output logic [jmwm_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output jmwm_pkg::cfg_t             cfg
);
  import jmwm_pkg::*;

  logic [1:0] index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_duty   <= MaxDutyReset;
      cfg.min_duty   <= MinDutyReset;
      cfg.deadband   <= DeadbandReset;
      cfg.spin_speed <= SpinSpeedReset;
    end else if (wr_en) begin
      case (index)
        REG_MAX_DUTY:   cfg.max_duty   <= pwdata[DutyW-1:0];
        REG_MIN_DUTY:   cfg.min_duty   <= pwdata[DutyW-1:0];
        REG_DEADBAND:   cfg.deadband   <= pwdata[DeadW-1:0];
        REG_SPIN_SPEED: cfg.spin_speed <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_MAX_DUTY:   prdata = DataW'(cfg.max_duty);
      REG_MIN_DUTY:   prdata = DataW'(cfg.min_duty);
      REG_DEADBAND:   prdata = DataW'(cfg.deadband);
      REG_SPIN_SPEED: prdata = DataW'(cfg.spin_speed);
      default:        prdata = '0;
    endcase
  end
endmodule

/* hdl/jmwm_scale_stage.sv */
// First pipeline stage: latch of the first off-centre sample, spin selection
// and axis scaling, registered into mid_t. Depends on jmwm_pkg and jmwm_stick_if.
module jmwm_scale_stage (
  input  logic                clk,
  input  logic                rst,
  input  jmwm_pkg::cfg_t      cfg,
  jmwm_stick_if.sink          stick,
  input  logic                mix_ready,
  output jmwm_pkg::mid_t      mid,
  output jmwm_pkg::status_t   status
);
  import jmwm_pkg::*;

  logic                   stick_seen;
  logic                   accept;
  logic                   active;
  logic [DutyW-1:0]       spin_lim;
  logic [DutyW-1:0]       spin_mag;
  logic                   spin_next;
  logic signed [ValW-1:0] fwd_next;
  logic signed [ValW-1:0] str_next;

  assign stick.ready = !mid.valid || mix_ready;
  assign accept      = stick.valid && stick.ready;
  assign active      = stick_seen || (stick.stick_x != Centre) || (stick.stick_y != Centre);

  // Limit to max first, then raise to min.
  assign spin_lim = (cfg.spin_speed > cfg.max_duty) ? cfg.max_duty : cfg.spin_speed;
  assign spin_mag = (spin_lim < cfg.min_duty) ? cfg.min_duty : spin_lim;

  // A spin carries the left wheel speed in str with the spin flag set; the mix
  // stage gives both left wheels that value and both right wheels its negation.
  always_comb begin
    spin_next = 1'b0;
    fwd_next  = '0;
    str_next  = '0;
    if (active) begin
      if (stick.buttons[SpinLeftBit]) begin
        spin_next = 1'b1;
        str_next  = -$signed({1'b0, spin_mag});
      end else if (stick.buttons[SpinRightBit]) begin
        spin_next = 1'b1;
        str_next  = $signed({1'b0, spin_mag});
      end else begin
        fwd_next = -axis_map(stick.stick_y, cfg.deadband, cfg.max_duty);
        str_next = axis_map(stick.stick_x, cfg.deadband, cfg.max_duty);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_seen <= 1'b0;
      mid.valid  <= 1'b0;
    end else begin
      if (stick.ready) begin
        mid.valid <= stick.valid;
      end
      if (accept) begin
        stick_seen <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid.spin <= spin_next;
      mid.fwd  <= fwd_next;
      mid.str  <= str_next;
    end
  end

  assign status.seen = stick_seen;
endmodule

/* hdl/jmwm_mix_stage.sv */
// Second pipeline stage: wheel mixing, clamping and stop threshold, into the
// result register. Depends on jmwm_pkg and jmwm_wheel_if.
module jmwm_mix_stage (
  input  logic           clk,
  input  logic           rst,
  input  jmwm_pkg::cfg_t cfg,
  input  jmwm_pkg::mid_t mid,
  output logic           mix_ready,
  jmwm_wheel_if.source   wheels
);
  import jmwm_pkg::*;

  logic signed [SumW-1:0] sum_a;
  logic signed [SumW-1:0] sum_b;
  wheel_t                 wheel_a;
  wheel_t                 wheel_b;
  logic                   load;

  assign mix_ready = !wheels.valid || wheels.ready;
  assign load      = mid.valid && mix_ready;

  // Front left gets forward plus strafe, front right the difference. When
  // mixing, each rear wheel copies its diagonal front wheel; when spinning,
  // it copies the front wheel on its own side.
  assign sum_a   = clamp_mag(SumW'(mid.fwd) + SumW'(mid.str), cfg.max_duty);
  assign sum_b   = clamp_mag(SumW'(mid.fwd) - SumW'(mid.str), cfg.max_duty);
  assign wheel_a = wheel_drive(sum_a, cfg.min_duty);
  assign wheel_b = wheel_drive(sum_b, cfg.min_duty);

  always_ff @(posedge clk) begin
    if (rst) begin
      wheels.valid <= 1'b0;
    end else if (mix_ready) begin
      wheels.valid <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wheels.front_left_duty  <= wheel_a.duty;
      wheels.front_left_dir   <= wheel_a.dir;
      wheels.front_right_duty <= wheel_b.duty;
      wheels.front_right_dir  <= wheel_b.dir;
      if (mid.spin) begin
        wheels.rear_left_duty  <= wheel_a.duty;
        wheels.rear_left_dir   <= wheel_a.dir;
        wheels.rear_right_duty <= wheel_b.duty;
        wheels.rear_right_dir  <= wheel_b.dir;
      end else begin
        wheels.rear_left_duty  <= wheel_b.duty;
        wheels.rear_left_dir   <= wheel_b.dir;
        wheels.rear_right_duty <= wheel_a.duty;
        wheels.rear_right_dir  <= wheel_a.dir;
      end
    end
  end
endmodule

/* hdl/joystick_mecanum_wheel_mixer_unit.sv */
// Top level of the joystick mecanum wheel mixer.
// Depends on jmwm_pkg, the channel interfaces, jmwm_cfg_regs, jmwm_scale_stage
// and jmwm_mix_stage.
//
// Usage:
//   A stick sample (stick_x, stick_y, buttons) is one transaction on the stick
//   channel; each sample yields exactly one transaction on the wheels channel
//   with a duty and a direction for all four wheels.
//   The path has two register stages: axis scaling and spin selection, then
//   wheel mixing and clamping. A sample is registered in each in turn.
//   With the wheels receiver ready, one sample per cycle is sustained.
//   When the wheels receiver stalls, the result register holds its result and
//   the scale stage still takes one more sample; ready on the stick channel
//   drops only when both stages are full.
//   Reset clears both stages, loads the register defaults (max 1000, min 0,
//   dead zone 10, spin 550) and clears the latch, so all wheels stay stopped
//   until a sample with an axis off centre.
//   Registers are written through the APB-style port at byte addresses 0, 4,
//   8 and 12, by the user only while no transaction is in flight; unenforced.
`include "assert_macros.svh"

module joystick_mecanum_wheel_mixer_unit (
  input  logic                       clk,
  input  logic                       rst,
  jmwm_stick_if.sink                 stick,
  jmwm_wheel_if.source               wheels,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jmwm_pkg::AddrW-1:0] paddr,
  input  logic [jmwm_pkg::DataW-1:0] pwdata,
  output logic [jmwm_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import jmwm_pkg::*;

  cfg_t    cfg;
  mid_t    mid;
  status_t status;
  logic    mix_ready;

  jmwm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jmwm_scale_stage u_scale_stage (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stick     (stick),
    .mix_ready (mix_ready),
    .mid       (mid),
    .status    (status)
  );

  jmwm_mix_stage u_mix_stage (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid       (mid),
    .mix_ready (mix_ready),
    .wheels    (wheels)
  );

  // With the result register empty the pipeline can always take a sample.
  `JMWM_ASSERT_IMPLY(a_ready_when_empty, !wheels.valid, stick.ready)
  // A moving wheel always carries a nonzero duty, a stopped one a zero duty.
  `JMWM_ASSERT_IMPLY(a_duty_dir_match, wheels.valid,
    ((wheels.front_left_duty == '0) == (wheels.front_left_dir == DIR_STOP)) &&
    ((wheels.front_right_duty == '0) == (wheels.front_right_dir == DIR_STOP)))
  // Each rear wheel copies a front wheel: the diagonal one when mixing, the one
  // on its own side when spinning.
  `JMWM_ASSERT_IMPLY(a_rear_copies_front, wheels.valid,
    ((wheels.rear_right_duty == wheels.front_left_duty) &&
     (wheels.rear_right_dir == wheels.front_left_dir) &&
     (wheels.rear_left_duty == wheels.front_right_duty) &&
     (wheels.rear_left_dir == wheels.front_right_dir)) ||
    ((wheels.rear_left_duty == wheels.front_left_duty) &&
     (wheels.rear_left_dir == wheels.front_left_dir) &&
     (wheels.rear_right_duty == wheels.front_right_duty) &&
     (wheels.rear_right_dir == wheels.front_right_dir)))
  // Once set, the latch holds until reset.
  `JMWM_ASSERT_IMPLY(a_latch_holds, !$past(rst), !$fell(status.seen))
endmodule

/* tb/tb_joystick_mecanum_wheel_mixer_unit.sv */
// Self-checking testbench for joystick_mecanum_wheel_mixer_unit.
// Drives stick samples and register writes, predicts the four wheel drives per sample.
// Depends on jmwm_pkg, jmwm_stick_if and jmwm_wheel_if.
`timescale 1ns / 1ps

module tb_joystick_mecanum_wheel_mixer_unit;
  import jmwm_pkg::*;

  localparam int StickDiv   = 128;
  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 22;

  typedef struct packed {
    wheel_t fl;
    wheel_t fr;
    wheel_t rl;
    wheel_t rr;
  } drive_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  jmwm_stick_if stick();
  jmwm_wheel_if wheels();

  joystick_mecanum_wheel_mixer_unit dut (
    .clk(clk),
    .rst(rst),
    .stick(stick),
    .wheels(wheels),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the register file and the start latch.
  cfg_t cfg_model;
  bit stick_seen_model;
  drive_set_t expected_wheels[$];
  int errors = 0;
  int samples_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  bit steady = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    wheels.ready <= !rst && (steady || $urandom_range(99) >= IdlePct);
  end

  function automatic int axis_value(input logic [AxisW-1:0] v);
    int vi;
    int dz;
    int mx;
    vi = int'(v);
    dz = int'(cfg_model.deadband);
    mx = int'(cfg_model.max_duty);
    if (vi > int'(Centre) + dz) return ((vi - int'(Centre)) * mx) / StickDiv;
    if (vi < int'(Centre) - dz) return -(((int'(Centre) - vi) * mx) / StickDiv);
    return 0;
  endfunction

  function automatic int limit_mag(input int v);
    int mx;
    mx = int'(cfg_model.max_duty);
    if (v > mx) return mx;
    if (v < -mx) return -mx;
    return v;
  endfunction

  function automatic wheel_t wheel_of(input int v);
    wheel_t w;
    int mn;
    mn = int'(cfg_model.min_duty);
    w.duty = '0;
    w.dir = DIR_STOP;
    if (v > mn) begin
      w.duty = DutyW'(v);
      w.dir = DIR_FWD;
    end else if (v < -mn) begin
      w.duty = DutyW'(-v);
      w.dir = DIR_BACK;
    end
    return w;
  endfunction

  // Advances the start latch, then computes the four wheel drives for one sample.
  function automatic drive_set_t predict_wheels(input logic [AxisW-1:0] x,
                                                input logic [AxisW-1:0] y,
                                                input logic [AxisW-1:0] b);
    drive_set_t r;
    int fl;
    int fr;
    int rl;
    int rr;
    int s;
    int fwd;
    int str;
    if (x != Centre || y != Centre) stick_seen_model = 1'b1;
    fl = 0;
    fr = 0;
    rl = 0;
    rr = 0;
    if (!stick_seen_model) begin
      fl = 0;
    end else if (b[SpinLeftBit] || b[SpinRightBit]) begin
      s = int'(cfg_model.spin_speed);
      if (s > int'(cfg_model.max_duty)) s = int'(cfg_model.max_duty);
      if (s < int'(cfg_model.min_duty)) s = int'(cfg_model.min_duty);
      // Spin left takes priority when both buttons are held.
      if (b[SpinLeftBit]) begin
        fl = -s; fr = s; rl = -s; rr = s;
      end else begin
        fl = s; fr = -s; rl = s; rr = -s;
      end
    end else begin
      fwd = -axis_value(y);
      str = axis_value(x);
      fl = limit_mag(fwd + str);
      fr = limit_mag(fwd - str);
      rl = fr;
      rr = fl;
    end
    r.fl = wheel_of(fl);
    r.fr = wheel_of(fr);
    r.rl = wheel_of(rl);
    r.rr = wheel_of(rr);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // All signals change only at rising edges, so the values at the falling edge
  // are those the next rising edge will see.
  always @(negedge clk) begin
    drive_set_t want;
    if (!rst && wheels.valid && wheels.ready) begin
      if (expected_wheels.size() == 0) begin
        $display("%0t: wheel transaction with no sample pending", $time);
        errors++;
      end else begin
        want = expected_wheels.pop_front();
        check_field("front_left_duty", want.fl.duty, wheels.front_left_duty);
        check_field("front_left_dir", want.fl.dir, wheels.front_left_dir);
        check_field("front_right_duty", want.fr.duty, wheels.front_right_duty);
        check_field("front_right_dir", want.fr.dir, wheels.front_right_dir);
        check_field("rear_left_duty", want.rl.duty, wheels.rear_left_duty);
        check_field("rear_left_dir", want.rl.dir, wheels.rear_left_dir);
        check_field("rear_right_duty", want.rr.duty, wheels.rear_right_duty);
        check_field("rear_right_dir", want.rr.dir, wheels.rear_right_dir);
      end
    end
  end

  // Leaves valid high on return; the caller either sends again or settles.
  task automatic send_sample(input logic [AxisW-1:0] x, input logic [AxisW-1:0] y,
                             input logic [AxisW-1:0] b);
    while (!steady && $urandom_range(99) < IdlePct) begin
      stick.valid <= 1'b0;
      @(posedge clk);
    end
    stick.valid <= 1'b1;
    stick.stick_x <= x;
    stick.stick_y <= y;
    stick.buttons <= b;
    @(negedge clk);
    while (!stick.ready) @(negedge clk);
    @(posedge clk);
    expected_wheels.push_back(predict_wheels(x, y, b));
    samples_sent++;
  endtask

  task automatic settle();
    stick.valid <= 1'b0;
    while (expected_wheels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Ends at the clock edge after the access edge so that back to back writes never
  // assign the bus signals twice at the same edge.
  task automatic write_register(input logic [1:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_DUTY:   cfg_model.max_duty = DutyW'(value);
      REG_MIN_DUTY:   cfg_model.min_duty = DutyW'(value);
      REG_DEADBAND:   cfg_model.deadband = DeadW'(value);
      REG_SPIN_SPEED: cfg_model.spin_speed = DutyW'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned mx, input int unsigned mn,
                               input int unsigned dz, input int unsigned sp);
    settle();
    write_register(REG_MAX_DUTY, mx);
    write_register(REG_MIN_DUTY, mn);
    write_register(REG_DEADBAND, dz);
    write_register(REG_SPIN_SPEED, sp);
    settings_used++;
  endtask

  // Axis values cluster at the rails and around the dead zone edges.
  function automatic logic [AxisW-1:0] pick_axis();
    int span;
    int v;
    span = int'(cfg_model.deadband) + 2;
    case ($urandom_range(3))
      0: v = $urandom_range(1) ? 0 : 255;
      1: v = int'(Centre) + int'($urandom_range(2 * span)) - span;
      default: v = $urandom_range(255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return AxisW'(v);
  endfunction

  task automatic send_random_samples(input int count);
    logic [AxisW-1:0] b;
    repeat (count) begin
      b = AxisW'($urandom_range(255));
      if ($urandom_range(99) < 65) begin
        b[SpinLeftBit] = 1'b0;
        b[SpinRightBit] = 1'b0;
      end
      send_sample(pick_axis(), pick_axis(), b);
    end
  endtask

  // Wheels stay stopped and buttons are ignored until an axis leaves centre.
  task automatic test_start_latch();
    send_sample(Centre, Centre, 8'h04);
    send_sample(Centre, Centre, 8'h02);
    send_sample(Centre, Centre, 8'hFF);
    send_sample(Centre, 8'd0, 8'h04);
    send_sample(Centre, Centre, 8'h00);
  endtask

  task automatic test_axis_extremes();
    send_sample(8'd0, Centre, 8'h00);
    send_sample(8'd255, Centre, 8'h00);
    send_sample(Centre, 8'd0, 8'h00);
    send_sample(Centre, 8'd255, 8'h00);
    send_sample(8'd0, 8'd0, 8'h00);
    send_sample(8'd255, 8'd255, 8'h00);
    send_sample(8'd0, 8'd255, 8'h00);
    send_sample(8'd255, 8'd0, 8'h00);
    // Both sides of the default dead zone edges.
    send_sample(8'd137, Centre, 8'h00);
    send_sample(8'd138, Centre, 8'h00);
    send_sample(8'd117, Centre, 8'h00);
    send_sample(8'd116, Centre, 8'h00);
  endtask

  task automatic test_spin_buttons();
    send_sample(8'd200, 8'd30, 8'h04);
    send_sample(8'd200, 8'd30, 8'h02);
    send_sample(8'd200, 8'd30, 8'h06);
    send_sample(8'd200, 8'd30, 8'hF9);
    send_sample(8'd200, 8'd30, 8'hFF);
  endtask

  task automatic test_register_corners();
    apply_setting(16383, 0, 0, 16383);
    send_random_samples(25);
    apply_setting(1, 0, 127, 0);
    send_random_samples(25);
    // A zero max scales every axis to nothing.
    apply_setting(0, 0, 10, 550);
    send_random_samples(20);
    // With min above max every wheel stops.
    apply_setting(100, 200, 5, 150);
    send_random_samples(20);
    // Spin equal to min stops the wheels; spin below min is raised to it.
    apply_setting(1000, 300, 10, 300);
    send_random_samples(20);
    apply_setting(1000, 300, 10, 50);
    send_random_samples(15);
    apply_setting(16383, 16383, 127, 16383);
    send_random_samples(20);
  endtask

  task automatic test_random_settings();
    int unsigned mx;
    int unsigned mn;
    int unsigned dz;
    int unsigned sp;
    for (int phase = 0; phase < 8; phase++) begin
      mx = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(1, 2000);
      mn = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(mx / 4);
      dz = $urandom_range(1) ? $urandom_range(20) : $urandom_range(127);
      sp = $urandom_range(16383);
      apply_setting(mx, mn, dz, sp);
      // Two phases run back to back with neither side idling.
      steady = (phase == 3 || phase == 4);
      send_random_samples(50);
    end
    steady = 1'b0;
  endtask

  initial begin
    cfg_model.max_duty = MaxDutyReset;
    cfg_model.min_duty = MinDutyReset;
    cfg_model.deadband = DeadbandReset;
    cfg_model.spin_speed = SpinSpeedReset;
    stick_seen_model = 1'b0;
    stick.valid <= 1'b0;
    stick.stick_x <= '0;
    stick.stick_y <= '0;
    stick.buttons <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_latch();
    test_axis_extremes();
    test_spin_buttons();
    test_register_corners();
    test_random_settings();

    settle();
    repeat (8) @(posedge clk);
    $display("Checked %0d stick samples under %0d register settings plus reset defaults,",
             samples_sent, settings_used);
    $display("covering the start latch, spin buttons, dead zone edges and duty clamps.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
